// ===== design/indexed_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Shared concurrent assertion forms for the indexed list engine.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("indexed list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("indexed list engine: next-cycle check failed");

`endif

// ===== design/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list engine package
// Types, codes and constants shared by the list cells and the top level.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int Capacity   = 16;
  localparam int ActionW    = 3;
  localparam int FieldPosW  = 5;
  localparam int ValueW     = 32;
  localparam int StatusW    = 2;
  // Widest cell index or count over the supported capacity range.
  localparam int PosMaxW    = 11;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_APPEND     = 3'd1,
    ACT_INSERT     = 3'd2,
    ACT_REMOVE     = 3'd3,
    ACT_READ       = 3'd4
  } ile_action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } ile_status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } ile_op_e;

  typedef struct packed {
    ile_op_e              op;
    logic [PosMaxW-1:0]   at;
    logic [ValueW-1:0]    value;
  } ile_cmd_t;

  typedef struct packed {
    logic [ActionW-1:0]   action;
    logic [FieldPosW-1:0] position;
    logic signed [ValueW-1:0] value;
  } ile_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [FieldPosW-1:0] list_length;
    ile_status_e          status;
  } ile_rsp_t;

endpackage

// ===== design/ile_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed list cell
// One list slot that holds, loads a new value, or takes a neighbour's value.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int Index = 0
) (
  input  logic                          clk_i,
  input  ile_pkg::ile_cmd_t             cmd_i,
  input  logic [ile_pkg::ValueW-1:0]    left_i,
  input  logic [ile_pkg::ValueW-1:0]    right_i,
  output logic [ile_pkg::ValueW-1:0]    data_o
);

  localparam logic [ile_pkg::PosMaxW-1:0] IdxV = ile_pkg::PosMaxW'(Index);

  logic [ile_pkg::ValueW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      ile_pkg::OP_INSERT: begin
        if (IdxV > cmd_i.at) begin
          data_d = left_i;
        end else if (IdxV == cmd_i.at) begin
          data_d = cmd_i.value;
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (IdxV >= cmd_i.at) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed values in a row of shifting cells, with insert,
// append, positional insert, remove and read requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// request   in         req_valid_i / req_ready_o  req_i (ile_req_t)
// response  out        rsp_valid_o / rsp_ready_i  rsp_o (ile_rsp_t)
//
// All cells shift or hold together on the edge that accepts a request, and
// the response is registered on that same edge.
// A new request is taken while the response register is empty or draining.
// Reset clears the length and the response valid flag; response data and
// cell contents are undefined until written.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_assert.svh"

module indexed_list_engine #(
  parameter int Capacity = ile_pkg::Capacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ile_pkg::ile_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output ile_pkg::ile_rsp_t rsp_o
);

  localparam int CntW    = $clog2(Capacity + 1);
  localparam int PosW    = (CntW > ile_pkg::FieldPosW) ? CntW : ile_pkg::FieldPosW;
  localparam int RdCells = (Capacity < 32) ? Capacity : 32;

  logic [CntW-1:0]           count_d, count_q;
  logic                      rsp_valid_d, rsp_valid_q;
  ile_pkg::ile_rsp_t         rsp_d, rsp_q;
  ile_pkg::ile_cmd_t         cmd;
  logic [ile_pkg::ValueW-1:0] cell_data [Capacity];
  logic [ile_pkg::ValueW-1:0] rd_data;
  logic [PosW-1:0]           pos_ext, cnt_ext;
  logic                      req_fire, full;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;
  assign pos_ext     = PosW'(req_i.position);
  assign cnt_ext     = PosW'(count_q);
  assign full        = (count_q == CntW'(Capacity));

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RdCells; i++) begin
      if (req_i.position == ile_pkg::FieldPosW'(i)) begin
        rd_data = cell_data[i];
      end
    end
  end

  always_comb begin
    cmd.op    = ile_pkg::OP_NONE;
    cmd.at    = '0;
    cmd.value = req_i.value;
    count_d   = count_q;
    rsp_d.read_value = '0;
    rsp_d.status     = ile_pkg::ST_OK;
    unique case (req_i.action)
      ile_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          rsp_d.status = ile_pkg::ST_FULL;
        end else begin
          cmd.op  = ile_pkg::OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      ile_pkg::ACT_APPEND: begin
        if (full) begin
          rsp_d.status = ile_pkg::ST_FULL;
        end else begin
          cmd.op  = ile_pkg::OP_INSERT;
          cmd.at  = ile_pkg::PosMaxW'(count_q);
          count_d = count_q + 1'b1;
        end
      end
      ile_pkg::ACT_INSERT: begin
        if (pos_ext > cnt_ext) begin
          rsp_d.status = ile_pkg::ST_BAD_POS;
        end else if (full) begin
          rsp_d.status = ile_pkg::ST_FULL;
        end else begin
          cmd.op  = ile_pkg::OP_INSERT;
          cmd.at  = ile_pkg::PosMaxW'(req_i.position);
          count_d = count_q + 1'b1;
        end
      end
      ile_pkg::ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          rsp_d.status = ile_pkg::ST_BAD_POS;
        end else begin
          cmd.op  = ile_pkg::OP_REMOVE;
          cmd.at  = ile_pkg::PosMaxW'(req_i.position);
          count_d = count_q - 1'b1;
        end
      end
      ile_pkg::ACT_READ: begin
        if (pos_ext >= cnt_ext) begin
          rsp_d.status = ile_pkg::ST_BAD_POS;
        end else begin
          rsp_d.read_value = rd_data;
        end
      end
      default: rsp_d.status = ile_pkg::ST_OK;
    endcase
    rsp_d.list_length = ile_pkg::FieldPosW'(count_d);
    if (!req_fire) begin
      cmd.op  = ile_pkg::OP_NONE;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [ile_pkg::ValueW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_left
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_right
      assign right = cell_data[g+1];
    end
    ile_cell #(
      .Index (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  assign rsp_valid_d = req_fire || (rsp_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `ILE_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Capacity))
  `ILE_ASSERT_NXT(a_fire_gives_rsp, clk_i, rst_ni, req_fire, rsp_valid_q)
  `ILE_ASSERT_NXT(a_reject_keeps_count, clk_i, rst_ni, req_fire && rsp_d.status != ile_pkg::ST_OK, count_q == $past(count_q))
  `ILE_ASSERT_NXT(a_insert_grows, clk_i, rst_ni, req_fire && cmd.op == ile_pkg::OP_INSERT, count_q == $past(count_q) + 1'b1)
  `ILE_ASSERT_IMP(a_reject_reads_zero, clk_i, rst_ni, rsp_valid_q && rsp_q.status != ile_pkg::ST_OK, rsp_q.read_value == '0)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Feeds list requests through the request channel and compares each response
// with a local model of the list that tracks the cells and the length.
// Directed requests cover empty and full lists, bad positions, extreme values
// and unused action codes; random requests then grow, shrink and read the
// list, with some malformed requests, while both channels idle in bursts.
// ----------------------------------------------------------------------------
module tb;

  localparam int RandomItems = 600;
  localparam int CalmTail    = 80;
  localparam int StallLimit  = 1000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              req_valid_i = 1'b0;
  ile_pkg::ile_req_t req_i       = '0;
  logic              rsp_ready_i = 1'b1;
  logic              req_ready_o;
  logic              rsp_valid_o;
  ile_pkg::ile_rsp_t rsp_o;

  indexed_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  ile_pkg::ile_req_t requests_queued[$];
  ile_pkg::ile_rsp_t replies_due[$];

  logic signed [ile_pkg::ValueW-1:0] list_model[ile_pkg::Capacity];
  int unsigned list_fill = 0;
  int unsigned planned_len = 0;
  int unsigned requests_taken = 0;
  int unsigned calm_from = 0;
  int unsigned cycle_no = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  function automatic ile_pkg::ile_rsp_t apply_request(ile_pkg::ile_req_t r);
    ile_pkg::ile_rsp_t rsp;
    int unsigned       pos;
    int unsigned       ins_at;
    logic              do_insert;
    rsp = '0;
    rsp.status = ile_pkg::ST_OK;
    pos = r.position;
    ins_at = 0;
    do_insert = 1'b0;
    case (r.action)
      ile_pkg::ACT_PUSH_FRONT: begin
        ins_at = 0;
        do_insert = 1'b1;
      end
      ile_pkg::ACT_APPEND: begin
        ins_at = list_fill;
        do_insert = 1'b1;
      end
      ile_pkg::ACT_INSERT: begin
        if (pos > list_fill) begin
          rsp.status = ile_pkg::ST_BAD_POS;
        end else begin
          ins_at = pos;
          do_insert = 1'b1;
        end
      end
      ile_pkg::ACT_REMOVE: begin
        if (pos >= list_fill) begin
          rsp.status = ile_pkg::ST_BAD_POS;
        end else begin
          for (int unsigned j = pos; j + 1 < list_fill; j++) list_model[j] = list_model[j + 1];
          list_fill--;
        end
      end
      ile_pkg::ACT_READ: begin
        if (pos >= list_fill) rsp.status = ile_pkg::ST_BAD_POS;
        else rsp.read_value = list_model[pos];
      end
      default: ;
    endcase
    if (do_insert) begin
      if (list_fill >= ile_pkg::Capacity) begin
        rsp.status = ile_pkg::ST_FULL;
      end else begin
        for (int unsigned j = list_fill; j > ins_at; j--) list_model[j] = list_model[j - 1];
        list_model[ins_at] = r.value;
        list_fill++;
      end
    end
    rsp.list_length = list_fill[ile_pkg::FieldPosW-1:0];
    return rsp;
  endfunction

  // Tracks the length the queued requests will leave, so that random requests
  // can aim at positions that exist.
  task automatic queue_request(logic [ile_pkg::ActionW-1:0] act,
                               logic [ile_pkg::FieldPosW-1:0] pos,
                               logic signed [ile_pkg::ValueW-1:0] val);
    ile_pkg::ile_req_t r;
    r.action = act;
    r.position = pos;
    r.value = val;
    requests_queued.push_back(r);
    case (act)
      ile_pkg::ACT_PUSH_FRONT, ile_pkg::ACT_APPEND:
        if (planned_len < ile_pkg::Capacity) planned_len++;
      ile_pkg::ACT_INSERT:
        if (pos <= planned_len && planned_len < ile_pkg::Capacity) planned_len++;
      ile_pkg::ACT_REMOVE: if (pos < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [ile_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(ile_pkg::ValueW-1){1'b0}}};
      1: return {1'b0, {(ile_pkg::ValueW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic idle_now();
    if (requests_taken >= calm_from || cycle_no[7:6] == 2'b11) return 1'b0;
    return $urandom_range(0, 4) == 0;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int unsigned trend;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned rem_pct;

    queue_request(ile_pkg::ACT_READ, 0, 1);
    queue_request(ile_pkg::ACT_REMOVE, 0, 2);
    queue_request(ile_pkg::ACT_INSERT, 1, 3);
    queue_request(ile_pkg::ACT_INSERT, 0, 32'sd17);
    queue_request(ile_pkg::ACT_PUSH_FRONT, 0, {1'b1, {(ile_pkg::ValueW-1){1'b0}}});
    queue_request(ile_pkg::ACT_APPEND, 31, {1'b0, {(ile_pkg::ValueW-1){1'b1}}});
    queue_request(ile_pkg::ACT_INSERT, 4, 5);
    queue_request(ile_pkg::ACT_INSERT, 3, '1);
    queue_request(ile_pkg::ACT_READ, 0, 0);
    queue_request(ile_pkg::ACT_READ, 3, 0);
    queue_request(ile_pkg::ACT_READ, 4, 0);
    queue_request(ile_pkg::ACT_REMOVE, 1, 0);
    for (int a = ile_pkg::ACT_READ + 1; a < (1 << ile_pkg::ActionW); a++)
      queue_request(ile_pkg::ActionW'(a), '1, '1);
    while (planned_len < ile_pkg::Capacity) queue_request(ile_pkg::ACT_PUSH_FRONT, 0, $urandom);
    queue_request(ile_pkg::ACT_PUSH_FRONT, 0, 6);
    queue_request(ile_pkg::ACT_APPEND, 0, 7);
    queue_request(ile_pkg::ACT_INSERT, ile_pkg::FieldPosW'(ile_pkg::Capacity), 8);
    queue_request(ile_pkg::ACT_INSERT, ile_pkg::FieldPosW'(ile_pkg::Capacity + 1), 9);
    queue_request(ile_pkg::ACT_READ, ile_pkg::FieldPosW'(ile_pkg::Capacity - 1), 0);
    queue_request(ile_pkg::ACT_READ, ile_pkg::FieldPosW'(ile_pkg::Capacity), 0);
    queue_request(ile_pkg::ACT_REMOVE, ile_pkg::FieldPosW'(ile_pkg::Capacity - 1), 0);

    trend = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) trend = $urandom_range(0, 2);
      ins_pct = (trend == 0) ? 60 : (trend == 1) ? 15 : 35;
      rem_pct = (trend == 0) ? 15 : (trend == 1) ? 60 : 30;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        queue_request(ile_pkg::ActionW'($urandom_range(0, (1 << ile_pkg::ActionW) - 1)),
                      ile_pkg::FieldPosW'($urandom_range(0, (1 << ile_pkg::FieldPosW) - 1)),
                      pick_value());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          case ($urandom_range(0, 2))
            0: queue_request(ile_pkg::ACT_PUSH_FRONT, ile_pkg::FieldPosW'($urandom),
                             pick_value());
            1: queue_request(ile_pkg::ACT_APPEND, ile_pkg::FieldPosW'($urandom),
                             pick_value());
            default: queue_request(ile_pkg::ACT_INSERT,
                                   ile_pkg::FieldPosW'($urandom_range(0, planned_len)),
                                   pick_value());
          endcase
        end else if (roll < ins_pct + rem_pct) begin
          queue_request(ile_pkg::ACT_REMOVE,
                        ile_pkg::FieldPosW'((planned_len == 0) ? 0 :
                                            $urandom_range(0, planned_len - 1)),
                        $urandom);
        end else begin
          queue_request(ile_pkg::ACT_READ,
                        ile_pkg::FieldPosW'((planned_len == 0) ? 0 :
                                            $urandom_range(0, planned_len - 1)),
                        $urandom);
        end
      end
    end
    calm_from = requests_queued.size() - CalmTail;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_queued.size() > 0 || req_valid_i) @(posedge clk_i);
    while (replies_due.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk_i) begin
    logic taken;
    if (rst_ni) begin
      taken = req_valid_i && req_ready_o;
      if (taken) begin
        replies_due.push_back(apply_request(req_i));
        requests_taken++;
      end
      if (!req_valid_i || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid_i <= 1'b0;
        end else if (requests_queued.size() > 0) begin
          req_i <= requests_queued.pop_front();
          req_valid_i <= 1'b1;
          if (idle_now()) send_gap = $urandom_range(1, 3);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i) begin
    ile_pkg::ile_rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("unexpected transaction, list_length", rsp_o.list_length, -1);
        end else begin
          want = replies_due.pop_front();
          if (rsp_o.read_value !== want.read_value)
            flag_mismatch("read_value", rsp_o.read_value, want.read_value);
          if (rsp_o.list_length !== want.list_length)
            flag_mismatch("list_length", rsp_o.list_length, want.list_length);
          if (rsp_o.status !== want.status)
            flag_mismatch("status", rsp_o.status, want.status);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready_i <= 1'b0;
      end else if (idle_now()) begin
        stall_left = $urandom_range(0, 2);
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    cycle_no++;
    if (rst_ni) begin
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ile_pkg.sv
design/ile_cell.sv
design/indexed_list_engine.sv
tb/sv/tb.sv
